@@ rtl/core/pee_pkg.sv @@
// Shared types, character codes and sequencer states for the postfix evaluator.
// No dependencies; compile first.
package pee_pkg;

  localparam int WORD_W   = 32;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int DIV_STEPS = 32;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_PCT    = 8'h25;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_PAREN = 2'd1;
  localparam status_t ST_DIV0  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_END,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_REM,
    OP_PAREN
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_R,
    S_POP_L,
    S_EXEC,
    S_DIV,
    S_SIGN,
    S_PUSH,
    S_EMIT
  } state_t;

  function automatic op_t decode_char(char_t c);
    op_t op;
    unique case (c)
      CH_NUL:               op = OP_END;
      CH_PLUS:              op = OP_ADD;
      CH_MINUS:             op = OP_SUB;
      CH_STAR:              op = OP_MUL;
      CH_SLASH:             op = OP_DIV;
      CH_PCT:               op = OP_REM;
      CH_LPAREN, CH_RPAREN: op = OP_PAREN;
      default:              op = OP_PUSH;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/core/pee_in_if.sv @@
// Input channel: one byte of postfix text per request.
// Depends on pee_pkg.
interface pee_in_if;
  logic            valid;
  logic            ready;
  pee_pkg::char_t  char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

@@ rtl/core/pee_out_if.sv @@
// Result channel: evaluated value, status and the sticky stack flags.
// Depends on pee_pkg.
interface pee_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      result_value;
  pee_pkg::status_t        status;
  logic                    underflow_seen;
  logic                    overflow_seen;

  modport source (output valid, output result_value, output status,
                  output underflow_seen, output overflow_seen, input ready);
  modport sink   (input valid, input result_value, input status,
                  input underflow_seen, input overflow_seen, output ready);
endinterface

@@ rtl/core/postfix_expression_evaluator_unit.sv @@
// Postfix evaluator top level; operand stack in a one-port-read synchronous RAM.
// A digit is pushed as it is taken; end of expression emits (waits on the result
// register); / and % run 32 iterations of the shared restoring divider.
// One byte in flight at a time; a waiting result blocks only the next emit.
// Synchronous active-low reset clears stack count, flags, state and result valid;
// the stack RAM is not cleared, the count alone decides which entries are live.
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  pee_in_if.sink     in_ch,
  pee_out_if.source  out_ch
);
  import pee_pkg::*;

  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  state_t state_r, state_nxt;
  op_t    op_r;
  op_t    in_op;
  logic   in_acc;
  logic   out_free;

  logic [CNT_W-1:0] count_r, count_nxt, count_m1;
  logic             unf_r, unf_nxt;
  logic             ovf_r, ovf_nxt;

  word_t   mem [STACK_DEPTH];
  word_t   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic    wr_en;
  word_t   wr_data;
  logic    push_req;
  word_t   push_val;
  word_t   pop_val;

  word_t   lhs_r, rhs_r, res_r;
  status_t st_r;
  word_t   mul_lo;
  word_t   lhs_abs, rhs_abs;

  word_t       dq_r, drem_r, dden_r;
  logic [4:0]  dcnt_r;
  logic        neg_q_r, neg_r_r;
  logic [32:0] rem_sh, rem_diff;
  logic        rem_ge;

  logic        out_valid_r;
  word_t       out_value_r;
  status_t     out_status_r;
  logic        out_unf_r, out_ovf_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_op    = decode_char(in_ch.char_in);
  assign out_free = !out_valid_r || out_ch.ready;
  assign pop_val  = (count_r == '0) ? '0 : rd_data_r;
  assign mul_lo   = lhs_r * rhs_r;
  assign lhs_abs  = lhs_r[31] ? (~lhs_r + 32'd1) : lhs_r;
  assign rhs_abs  = rhs_r[31] ? (~rhs_r + 32'd1) : rhs_r;

  // one restoring divider step
  assign rem_sh   = {drem_r, dq_r[31]};
  assign rem_diff = rem_sh - {1'b0, dden_r};
  assign rem_ge   = !rem_diff[32];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_op != OP_PUSH) state_nxt = S_POP_R;
      S_POP_R: state_nxt = (op_r == OP_END) ? S_EMIT : S_POP_L;
      S_POP_L: state_nxt = (op_r == OP_PAREN) ? S_EMIT : S_EXEC;
      S_EXEC: begin
        if (op_r == OP_DIV || op_r == OP_REM) begin
          state_nxt = (rhs_r == '0) ? S_EMIT : S_DIV;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_DIV:   if (dcnt_r == DIV_LAST) state_nxt = S_SIGN;
      S_SIGN:  state_nxt = S_PUSH;
      S_PUSH:  state_nxt = S_IDLE;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and stack control
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    count_nxt   = count_r;
    unf_nxt     = unf_r;
    ovf_nxt     = ovf_r;
    push_req    = 1'b0;
    push_val    = res_r;
    wr_en       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_PUSH) begin
          push_req = 1'b1;
          push_val = {24'd0, in_ch.char_in} - {24'd0, CH_ZERO};
        end
      end
      S_POP_R, S_POP_L: begin
        if (count_r == '0) begin
          unf_nxt = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      S_PUSH: push_req = 1'b1;
      S_EMIT: begin
        if (out_free) begin
          count_nxt = '0;
          unf_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
    if (push_req) begin
      if (count_r >= CNT_FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign wr_data  = push_val;
  assign wr_addr  = count_r[AW-1:0];
  // keep the read port on the top of stack as it stands after this edge
  assign count_m1 = count_nxt - 1'b1;
  assign rd_addr  = (count_nxt == '0) ? '0 : count_m1[AW-1:0];

  // forward a word written to the entry that is read in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      unf_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      unf_r   <= unf_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_acc) op_r <= in_op;
      S_POP_R: begin
        rhs_r <= pop_val;
        res_r <= pop_val;
        st_r  <= ST_OK;
      end
      S_POP_L: begin
        lhs_r <= pop_val;
        res_r <= '0;
        st_r  <= ST_PAREN;
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: res_r <= lhs_r + rhs_r;
          OP_SUB: res_r <= lhs_r - rhs_r;
          OP_MUL: res_r <= mul_lo;
          OP_DIV, OP_REM: begin
            res_r   <= '0;
            st_r    <= ST_DIV0;
            dq_r    <= lhs_abs;
            dden_r  <= rhs_abs;
            drem_r  <= '0;
            dcnt_r  <= '0;
            neg_q_r <= lhs_r[31] ^ rhs_r[31];
            neg_r_r <= lhs_r[31];
          end
          default: ;
        endcase
      end
      S_DIV: begin
        dq_r   <= {dq_r[30:0], rem_ge};
        drem_r <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
        dcnt_r <= dcnt_r + 5'd1;
      end
      S_SIGN: begin
        if (op_r == OP_DIV) begin
          res_r <= neg_q_r ? (~dq_r + 32'd1) : dq_r;
        end else begin
          res_r <= neg_r_r ? (~drem_r + 32'd1) : drem_r;
        end
      end
      default: ;
    endcase
  end

  // result register: hold until taken, load when the sequencer emits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_value_r  <= res_r;
      out_status_r <= st_r;
      out_unf_r    <= unf_r;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_value_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.underflow_seen = out_unf_r;
  assign out_ch.overflow_seen  = out_ovf_r;

endmodule
